// ===== hw/rtl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, types and register codes for the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

	// Fraction bits of both the quaternion and the vector components.
	localparam int FRAC_BITS = 16;

	// Field widths.
	localparam int QW = 18;          // configured quaternion component
	localparam int VW = 32;          // vector component in and out
	localparam int RW = QW + 1;      // quaternion component after a sign flip
	localparam int MW = RW + VW;     // one product of the first Hamilton product
	localparam int PW = MW + 2;      // sum of three such products
	localparam int LOW_W = 32;       // low slice of a first-product term
	localparam int HIW = PW - LOW_W; // high slice, signed
	localparam int HMW = HIW + RW;   // high slice times a coefficient
	localparam int LMW = LOW_W + 1 + RW; // low slice times a coefficient
	localparam int HSW = HMW + 2;    // sum of four high products
	localparam int LSW = LMW + 2;    // sum of four low products
	// Exact second product, wide enough to leave a 44-bit integer part.
	localparam int TW = (2 * FRAC_BITS + VW + 2 > HSW + LOW_W + 2) ?
		(2 * FRAC_BITS + VW + 2) : (HSW + LOW_W + 2);
	localparam int RNDW = TW - 2 * FRAC_BITS; // width after dropping fraction bits

	typedef logic signed [QW-1:0]   quat_t;
	typedef logic signed [RW-1:0]   qr_t;
	typedef logic signed [VW-1:0]   vec_t;
	typedef logic signed [MW-1:0]   mul_t;
	typedef logic signed [PW-1:0]   prod_t;
	typedef logic signed [HMW-1:0]  hmul_t;
	typedef logic signed [LMW-1:0]  lmul_t;
	typedef logic signed [HSW-1:0]  hsum_t;
	typedef logic signed [LSW-1:0]  lsum_t;
	typedef logic signed [TW-1:0]   wide_t;
	typedef logic signed [RNDW-1:0] rnd_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_QUAT_SCALAR = 2'd0,
		REG_QUAT_I      = 2'd1,
		REG_QUAT_J      = 2'd2,
		REG_QUAT_K      = 2'd3
	} cfg_reg_t;

	// Reset value of the scalar part: 1.0.
	localparam quat_t QUAT_ONE = quat_t'(1) <<< FRAC_BITS;

endpackage

// ===== hw/rtl/quaternion_vector_rotation.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotation
// Rotates a stream of fixed-point 3-vectors by a configured quaternion,
// q*(0,v)*conj(q) or conj(q)*(0,v)*q, rounded and saturated.
// Throughput: one word per cycle unless out_ready holds the output back;
// seven pipeline stages, each with a valid bit. A stage refills as soon as
// the one after it moves, so bubbles close up.
// Reset clears all valid bits and loads the identity quaternion.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_addr,
	input  logic [qvr_pkg::QW-1:0] cfg_wdata,
	// input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  func,
	input  logic signed [qvr_pkg::VW-1:0] vec_x,
	input  logic signed [qvr_pkg::VW-1:0] vec_y,
	input  logic signed [qvr_pkg::VW-1:0] vec_z,
	// output channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [qvr_pkg::VW-1:0] rot_x,
	output logic signed [qvr_pkg::VW-1:0] rot_y,
	output logic signed [qvr_pkg::VW-1:0] rot_z,
	output logic                  clipped
);

	// Saturation limits at the width of the rounded value.
	localparam qvr_pkg::rnd_t SAT_MAX = qvr_pkg::rnd_t'({1'b0, {(qvr_pkg::VW-1){1'b1}}});
	localparam qvr_pkg::rnd_t SAT_MIN = -SAT_MAX - qvr_pkg::rnd_t'(1);
	// Half an output unit at the exact product's scale.
	localparam qvr_pkg::wide_t RND_HALF = qvr_pkg::wide_t'(1) <<< (2 * qvr_pkg::FRAC_BITS - 1);

	// Configuration registers.
	qvr_pkg::quat_t quat_q [4];

	// Pipeline valid bits and stage enables.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	// Stage registers.
	qvr_pkg::qr_t   r_s1 [4];
	qvr_pkg::vec_t  v_s1 [3];
	qvr_pkg::qr_t   r_s2 [4];
	qvr_pkg::mul_t  m_s2 [12];
	qvr_pkg::prod_t p_s3 [4];
	qvr_pkg::qr_t   c_s3 [3][4];
	qvr_pkg::hmul_t hp_s4 [3][4];
	qvr_pkg::lmul_t lp_s4 [3][4];
	qvr_pkg::hsum_t a_s5 [3];
	qvr_pkg::lsum_t b_s5 [3];
	qvr_pkg::wide_t t_s6 [3];
	qvr_pkg::vec_t  rot_s7 [3];
	logic           clip_s7;

	// Next-stage values.
	qvr_pkg::qr_t   r_sel [4];
	qvr_pkg::mul_t  m_nxt [12];
	qvr_pkg::prod_t p_nxt [4];
	qvr_pkg::qr_t   c_nxt [3][4];
	qvr_pkg::hmul_t hp_nxt [3][4];
	qvr_pkg::lmul_t lp_nxt [3][4];
	qvr_pkg::hsum_t a_nxt [3];
	qvr_pkg::lsum_t b_nxt [3];
	qvr_pkg::wide_t t_nxt [3];
	qvr_pkg::vec_t  rot_nxt [3];
	logic [2:0]     sat_nxt;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q[0] <= qvr_pkg::QUAT_ONE;
			quat_q[1] <= '0;
			quat_q[2] <= '0;
			quat_q[3] <= '0;
		end else if (cfg_we) begin
			case (qvr_pkg::cfg_reg_t'(cfg_addr))
				qvr_pkg::REG_QUAT_SCALAR: quat_q[0] <= cfg_wdata;
				qvr_pkg::REG_QUAT_I:      quat_q[1] <= cfg_wdata;
				qvr_pkg::REG_QUAT_J:      quat_q[2] <= cfg_wdata;
				qvr_pkg::REG_QUAT_K:      quat_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or its contents move on.
	assign en7 = !vld_s7 || out_ready;
	assign en6 = !vld_s6 || en7;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
			if (en7) vld_s7 <= vld_s6;
		end
	end

	// Stage 1: the reverse rotation uses conj(q), so flip the vector part.
	always_comb begin
		r_sel[0] = qvr_pkg::qr_t'(quat_q[0]);
		for (int i = 1; i < 4; i++) begin
			r_sel[i] = func ? -qvr_pkg::qr_t'(quat_q[i]) : qvr_pkg::qr_t'(quat_q[i]);
		end
	end

	// Stage 2: the twelve products of r*(0,v).
	always_comb begin
		m_nxt[0]  = qvr_pkg::mul_t'(r_s1[1]) * qvr_pkg::mul_t'(v_s1[0]);
		m_nxt[1]  = qvr_pkg::mul_t'(r_s1[2]) * qvr_pkg::mul_t'(v_s1[1]);
		m_nxt[2]  = qvr_pkg::mul_t'(r_s1[3]) * qvr_pkg::mul_t'(v_s1[2]);
		m_nxt[3]  = qvr_pkg::mul_t'(r_s1[0]) * qvr_pkg::mul_t'(v_s1[0]);
		m_nxt[4]  = qvr_pkg::mul_t'(r_s1[2]) * qvr_pkg::mul_t'(v_s1[2]);
		m_nxt[5]  = qvr_pkg::mul_t'(r_s1[3]) * qvr_pkg::mul_t'(v_s1[1]);
		m_nxt[6]  = qvr_pkg::mul_t'(r_s1[0]) * qvr_pkg::mul_t'(v_s1[1]);
		m_nxt[7]  = qvr_pkg::mul_t'(r_s1[1]) * qvr_pkg::mul_t'(v_s1[2]);
		m_nxt[8]  = qvr_pkg::mul_t'(r_s1[3]) * qvr_pkg::mul_t'(v_s1[0]);
		m_nxt[9]  = qvr_pkg::mul_t'(r_s1[0]) * qvr_pkg::mul_t'(v_s1[2]);
		m_nxt[10] = qvr_pkg::mul_t'(r_s1[1]) * qvr_pkg::mul_t'(v_s1[1]);
		m_nxt[11] = qvr_pkg::mul_t'(r_s1[2]) * qvr_pkg::mul_t'(v_s1[0]);
	end

	// Stage 3: the four terms of the first product, and the coefficients
	// of conj(r) that each output component needs.
	always_comb begin
		p_nxt[0] = -qvr_pkg::prod_t'(m_s2[0]) - qvr_pkg::prod_t'(m_s2[1])
			- qvr_pkg::prod_t'(m_s2[2]);
		p_nxt[1] = qvr_pkg::prod_t'(m_s2[3]) + qvr_pkg::prod_t'(m_s2[4])
			- qvr_pkg::prod_t'(m_s2[5]);
		p_nxt[2] = qvr_pkg::prod_t'(m_s2[6]) - qvr_pkg::prod_t'(m_s2[7])
			+ qvr_pkg::prod_t'(m_s2[8]);
		p_nxt[3] = qvr_pkg::prod_t'(m_s2[9]) + qvr_pkg::prod_t'(m_s2[10])
			- qvr_pkg::prod_t'(m_s2[11]);
		c_nxt[0][0] = -r_s2[1];
		c_nxt[0][1] =  r_s2[0];
		c_nxt[0][2] = -r_s2[3];
		c_nxt[0][3] =  r_s2[2];
		c_nxt[1][0] = -r_s2[2];
		c_nxt[1][1] =  r_s2[3];
		c_nxt[1][2] =  r_s2[0];
		c_nxt[1][3] = -r_s2[1];
		c_nxt[2][0] = -r_s2[3];
		c_nxt[2][1] = -r_s2[2];
		c_nxt[2][2] =  r_s2[1];
		c_nxt[2][3] =  r_s2[0];
	end

	// Stage 4: each first-product term is split into a signed high slice and
	// an unsigned low slice, each multiplied by its coefficient.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 4; i++) begin
				hp_nxt[k][i] = qvr_pkg::hmul_t'($signed(p_s3[i][qvr_pkg::PW-1:qvr_pkg::LOW_W]))
					* qvr_pkg::hmul_t'(c_s3[k][i]);
				lp_nxt[k][i] = qvr_pkg::lmul_t'($signed({1'b0, p_s3[i][qvr_pkg::LOW_W-1:0]}))
					* qvr_pkg::lmul_t'(c_s3[k][i]);
			end
		end
	end

	// Stage 5: sum the high and the low partial products separately.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a_nxt[k] = qvr_pkg::hsum_t'(hp_s4[k][0]) + qvr_pkg::hsum_t'(hp_s4[k][1])
				+ qvr_pkg::hsum_t'(hp_s4[k][2]) + qvr_pkg::hsum_t'(hp_s4[k][3]);
			b_nxt[k] = qvr_pkg::lsum_t'(lp_s4[k][0]) + qvr_pkg::lsum_t'(lp_s4[k][1])
				+ qvr_pkg::lsum_t'(lp_s4[k][2]) + qvr_pkg::lsum_t'(lp_s4[k][3]);
		end
	end

	// Stage 6: rejoin the halves into the exact sum and add half an LSB.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			t_nxt[k] = (qvr_pkg::wide_t'(a_s5[k]) <<< qvr_pkg::LOW_W)
				+ qvr_pkg::wide_t'(b_s5[k]) + RND_HALF;
		end
	end

	// Stage 7: drop the fraction bits (floor) and saturate to 32 bits.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			automatic qvr_pkg::rnd_t r = qvr_pkg::rnd_t'(t_s6[k] >>> (2 * qvr_pkg::FRAC_BITS));
			if (r > SAT_MAX) begin
				rot_nxt[k] = qvr_pkg::vec_t'(SAT_MAX);
				sat_nxt[k] = 1'b1;
			end else if (r < SAT_MIN) begin
				rot_nxt[k] = qvr_pkg::vec_t'(SAT_MIN);
				sat_nxt[k] = 1'b1;
			end else begin
				rot_nxt[k] = qvr_pkg::vec_t'(r);
				sat_nxt[k] = 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en1) begin
			r_s1 <= r_sel;
			v_s1[0] <= vec_x;
			v_s1[1] <= vec_y;
			v_s1[2] <= vec_z;
		end
		if (en2) begin
			r_s2 <= r_s1;
			m_s2 <= m_nxt;
		end
		if (en3) begin
			p_s3 <= p_nxt;
			c_s3 <= c_nxt;
		end
		if (en4) begin
			hp_s4 <= hp_nxt;
			lp_s4 <= lp_nxt;
		end
		if (en5) begin
			a_s5 <= a_nxt;
			b_s5 <= b_nxt;
		end
		if (en6) begin
			t_s6 <= t_nxt;
		end
		if (en7) begin
			rot_s7 <= rot_nxt;
			clip_s7 <= |sat_nxt;
		end
	end

	assign out_valid = vld_s7;
	assign rot_x = rot_s7[0];
	assign rot_y = rot_s7[1];
	assign rot_z = rot_s7[2];
	assign clipped = clip_s7;

	// With the output stage empty every stage can move, so the input is open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output stage is empty");

	// Words in flight change only by what enters and what leaves.
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> $countones({vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7})
			== $past($countones({vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7}))
			+ $past(in_valid && in_ready && arst_n) - $past(out_valid && out_ready))
		else $error("pipeline lost or duplicated a word");

	// A saturation flag always comes with a component at a limit.
	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |->
			rot_x == qvr_pkg::vec_t'(SAT_MAX) || rot_x == qvr_pkg::vec_t'(SAT_MIN) ||
			rot_y == qvr_pkg::vec_t'(SAT_MAX) || rot_y == qvr_pkg::vec_t'(SAT_MIN) ||
			rot_z == qvr_pkg::vec_t'(SAT_MAX) || rot_z == qvr_pkg::vec_t'(SAT_MIN))
		else $error("clipped set with no component at a limit");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quaternion_vector_rotation. A queue of vector words
// feeds a handshake driver, and every accepted word is rotated by a bit-exact
// model of the datapath. A monitor compares each output word against the
// oldest prediction. The run covers rounding ties, saturation in both
// directions, non-unit quaternions and several sender and receiver idle
// patterns, including a long receiver stall that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_DEPTH   = 7;
	localparam int LONG_HOLD    = 80;
	localparam int PHASE_WORDS  = 150;
	localparam int RAND_PHASES  = 8;
	localparam int TIMEOUT_NS   = 200000 * 12;

	localparam qvr_pkg::vec_t VEC_MAX = 32'sh7FFF_FFFF;
	localparam qvr_pkg::vec_t VEC_MIN = 32'sh8000_0000;

	// Wide enough to hold the exact second product with room to spare.
	typedef logic signed [127:0] acc_t;

	typedef struct packed {
		logic f;
		qvr_pkg::vec_t x;
		qvr_pkg::vec_t y;
		qvr_pkg::vec_t z;
	} vec_word_t;

	typedef struct packed {
		qvr_pkg::vec_t x;
		qvr_pkg::vec_t y;
		qvr_pkg::vec_t z;
		logic clip;
	} rot_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = '0;
	logic [qvr_pkg::QW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = 1'b0;
	qvr_pkg::vec_t vec_x = '0;
	qvr_pkg::vec_t vec_y = '0;
	qvr_pkg::vec_t vec_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	qvr_pkg::vec_t rot_x;
	qvr_pkg::vec_t rot_y;
	qvr_pkg::vec_t rot_z;
	logic clipped;

	quaternion_vector_rotation u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.vec_x     (vec_x),
		.vec_y     (vec_y),
		.vec_z     (vec_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rot_x     (rot_x),
		.rot_y     (rot_y),
		.rot_z     (rot_z),
		.clipped   (clipped)
	);

	// Testbench copy of the quaternion registers.
	qvr_pkg::quat_t quat_reg [4];

	vec_word_t word_queue[$];
	rot_word_t expected_rot[$];
	vec_word_t next_word;
	rot_word_t want;
	rot_word_t got;

	int pushed_count   = 0;
	int accepted_count = 0;
	int back_count     = 0;
	int result_count   = 0;
	int clipped_count  = 0;
	int error_count    = 0;
	int quat_settings  = 1;
	int tx_idle_pct    = 0;
	int rx_stall_pct   = 0;
	int hold_cycles    = 0;
	logic rx_hold = 1'b0;
	event hold_kick;

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Rounds an exact sum with 2*FRAC_BITS fraction bits to nearest, ties up,
	// then clamps it to the 32-bit output range.
	function automatic qvr_pkg::vec_t round_sat(acc_t exact, inout logic clip);
		acc_t r;
		r = (exact + (acc_t'(1) <<< (2 * qvr_pkg::FRAC_BITS - 1)))
			>>> (2 * qvr_pkg::FRAC_BITS);
		if (r > acc_t'(VEC_MAX)) begin
			clip = 1'b1;
			r = acc_t'(VEC_MAX);
		end else if (r < acc_t'(VEC_MIN)) begin
			clip = 1'b1;
			r = acc_t'(VEC_MIN);
		end
		return qvr_pkg::vec_t'(r);
	endfunction

	// Forms r*(0,v)*conj(r), with r = q for a forward word and conj(q) for a
	// backward one. The first product stays exact; the second is rounded once.
	function automatic rot_word_t rotate_vector(vec_word_t w);
		acc_t qs, qx, qy, qz, ax, ay, az;
		acc_t p0, p1, p2, p3;
		rot_word_t r;
		qs = acc_t'(quat_reg[qvr_pkg::REG_QUAT_SCALAR]);
		qx = acc_t'(quat_reg[qvr_pkg::REG_QUAT_I]);
		qy = acc_t'(quat_reg[qvr_pkg::REG_QUAT_J]);
		qz = acc_t'(quat_reg[qvr_pkg::REG_QUAT_K]);
		if (w.f) begin
			qx = -qx;
			qy = -qy;
			qz = -qz;
		end
		ax = acc_t'(w.x);
		ay = acc_t'(w.y);
		az = acc_t'(w.z);
		p0 = -qx * ax - qy * ay - qz * az;
		p1 = qs * ax + qy * az - qz * ay;
		p2 = qs * ay - qx * az + qz * ax;
		p3 = qs * az + qx * ay - qy * ax;
		r.clip = 1'b0;
		r.x = round_sat(-p0 * qx + p1 * qs - p2 * qz + p3 * qy, r.clip);
		r.y = round_sat(-p0 * qy + p1 * qz + p2 * qs - p3 * qx, r.clip);
		r.z = round_sat(-p0 * qz - p1 * qy + p2 * qx + p3 * qs, r.clip);
		return r;
	endfunction

	// Input driver: holds a word until it is taken, then offers the next one
	// unless the sender idles this cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_rot.push_back(rotate_vector('{func, vec_x, vec_y, vec_z}));
				accepted_count++;
				if (func)
					back_count++;
			end
			if (!in_valid || in_ready) begin
				if (word_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					next_word = word_queue.pop_front();
					in_valid <= 1'b1;
					func <= next_word.f;
					vec_x <= next_word.x;
					vec_y <= next_word.y;
					vec_z <= next_word.z;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus the long hold-off when it is active.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// Long receiver hold-off, timed in cycles here so the sender keeps going.
	always begin
		@(hold_kick);
		@(posedge clk);
		rx_hold <= 1'b1;
		for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++)
			@(posedge clk);
		rx_hold <= 1'b0;
	end

	// Output monitor: every accepted word is checked against the oldest
	// prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got = '{rot_x, rot_y, rot_z, clipped};
			result_count++;
			if (clipped)
				clipped_count++;
			if (expected_rot.size() == 0) begin
				if (error_count < 10)
					$display("unexpected word at %0t: x=%h y=%h z=%h clipped=%b",
						$realtime, got.x, got.y, got.z, got.clip);
				error_count++;
			end else begin
				want = expected_rot.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
						got.clip !== want.clip) begin
					if (error_count < 10)
						$display("mismatch at %0t: expected x=%h y=%h z=%h clipped=%b, %s",
							$realtime, want.x, want.y, want.z, want.clip,
							$sformatf("got x=%h y=%h z=%h clipped=%b",
								got.x, got.y, got.z, got.clip));
					error_count++;
				end
			end
		end
	end

	task automatic queue_word(logic f, qvr_pkg::vec_t x, qvr_pkg::vec_t y,
			qvr_pkg::vec_t z);
		word_queue.push_back('{f, x, y, z});
		pushed_count++;
	endtask

	// Waits until every queued word is taken and every result has come back.
	task automatic wait_drained();
		while (accepted_count != pushed_count || expected_rot.size() != 0)
			@(posedge clk);
	endtask

	// Writes all four registers; only called while the pipeline is empty.
	task automatic load_quaternion(qvr_pkg::quat_t s, qvr_pkg::quat_t i,
			qvr_pkg::quat_t j, qvr_pkg::quat_t k);
		qvr_pkg::quat_t vals [4];
		vals = '{s, i, j, k};
		for (int n = 0; n < 4; n++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_addr <= qvr_pkg::cfg_reg_t'(n);
			cfg_wdata <= vals[n];
			@(posedge clk);
			cfg_we <= 1'b0;
			quat_reg[n] = vals[n];
		end
		quat_settings++;
	endtask

	function automatic qvr_pkg::vec_t random_component();
		case ($urandom_range(0, 3))
			0: return qvr_pkg::vec_t'($urandom);
			1: return qvr_pkg::vec_t'(int'($urandom_range(0, 33554431)) - 16777216);
			2: return qvr_pkg::vec_t'(int'($urandom_range(0, 1048575)) - 524288);
			default: case ($urandom_range(0, 3))
				0: return VEC_MAX;
				1: return VEC_MIN;
				2: return qvr_pkg::vec_t'(0);
				default: return qvr_pkg::vec_t'(-1);
			endcase
		endcase
	endfunction

	// Either any 18-bit pattern or a component no larger than about 0.7.
	function automatic qvr_pkg::quat_t random_quat(logic moderate);
		if (moderate)
			return qvr_pkg::quat_t'(int'($urandom_range(0, 92682)) - 46341);
		return qvr_pkg::quat_t'($urandom_range(0, 262143));
	endfunction

	// Stimulus: directed corner cases first, then random phases.
	initial begin
		quat_reg[qvr_pkg::REG_QUAT_SCALAR] = qvr_pkg::QUAT_ONE;
		quat_reg[qvr_pkg::REG_QUAT_I] = '0;
		quat_reg[qvr_pkg::REG_QUAT_J] = '0;
		quat_reg[qvr_pkg::REG_QUAT_K] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Identity quaternion from reset: words pass through unchanged.
		queue_word(1'b0, 0, 0, 0);
		queue_word(1'b0, VEC_MAX, VEC_MIN, -1);
		queue_word(1'b1, VEC_MIN, VEC_MAX, 1);
		queue_word(1'b1, 32'h1234_5678, 32'hEDCB_A987, 32'h0001_0000);
		wait_drained();

		// Scale by 2^-16: exact halves check that ties round upward.
		load_quaternion(256, 0, 0, 0);
		queue_word(1'b0, 32768, -32768, 32769);
		queue_word(1'b1, -32769, 98304, -98304);
		queue_word(1'b0, 1, -1, 65535);
		wait_drained();

		// Largest non-unit quaternion: saturates high and low.
		load_quaternion(131071, -131072, 131071, -131072);
		queue_word(1'b0, VEC_MAX, VEC_MAX, VEC_MAX);
		queue_word(1'b1, VEC_MIN, VEC_MIN, VEC_MIN);
		queue_word(1'b0, VEC_MAX, VEC_MIN, 0);
		queue_word(1'b1, 65536, -65536, 65536);
		wait_drained();

		// Quarter turn about z, both directions.
		load_quaternion(46341, 0, 0, 46341);
		queue_word(1'b0, 65536, 0, 0);
		queue_word(1'b1, 65536, 0, 0);
		queue_word(1'b0, 0, 65536, -65536);
		wait_drained();

		// Most negative value in every register.
		load_quaternion(-131072, -131072, -131072, -131072);
		queue_word(1'b0, VEC_MIN, VEC_MAX, 1);
		queue_word(1'b1, -1, -1, -1);
		wait_drained();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
				default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
			endcase
			if (ph == 6)
				load_quaternion(131071, 131071, 131071, 131071);
			else if (ph == 7)
				load_quaternion(-131072, 0, 131071, 0);
			else
				load_quaternion(random_quat(ph % 2 == 0), random_quat(ph % 2 == 0),
					random_quat(ph % 2 == 0), random_quat(ph % 2 == 0));
			// Hold the receiver off as this phase begins.
			if (ph == 2)
				-> hold_kick;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				queue_word(1'($urandom_range(0, 1)), random_component(),
					random_component(), random_component());
				// Sender pause halfway until the pipeline has emptied.
				if (ph == 3 && n == PHASE_WORDS / 2)
					wait_drained();
			end
			wait_drained();
		end

		repeat (3 * PIPE_DEPTH) @(posedge clk);
		$display("Rotated %0d vectors (%0d rotated back) under %0d quaternion settings,",
			accepted_count, back_count, quat_settings);
		$display("%0d output words checked, %0d of them saturated, %0d errors.",
			result_count, clipped_count, error_count);
		if (error_count == 0 && expected_rot.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog.
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d results outstanding.", expected_rot.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/qvr_pkg.sv
hw/rtl/quaternion_vector_rotation.sv
dv/tb.sv
